// ----- sv/les_pkg.sv -----
// Package for the LED effect sequencer: types, codes and shared helpers.
package les_pkg;

	localparam int TIME_BITS = 16;
	localparam int LEN_BITS  = 16;
	localparam int CMP_BITS  = (TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS;
	localparam int HOLD_BITS = 10;
	localparam int COLOR_BITS = 24;
	localparam int LEVEL_BITS = 7;
	localparam logic [LEVEL_BITS-1:0] FADE_TOP = 7'd100;
	localparam logic [TIME_BITS-1:0] TIMER_MAX = {TIME_BITS{1'b1}};

	// Reciprocal of 100 scaled by 2^23; exact floor for every 16-bit value.
	localparam logic [16:0] RECIP_100 = 17'd83887;
	localparam int RECIP_SHIFT = 23;

	localparam logic [2:0] MODE_OFF     = 3'd0;
	localparam logic [2:0] MODE_ON      = 3'd1;
	localparam logic [2:0] MODE_FLICKER = 3'd2;
	localparam logic [2:0] MODE_FADE    = 3'd3;
	localparam logic [2:0] MODE_ONESHOT = 3'd4;

	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_COLOR    = 2'd1;
	localparam logic [1:0] REG_ON_TIME  = 2'd2;
	localparam logic [1:0] REG_OFF_TIME = 2'd3;

	typedef struct packed {
		logic tick;
		logic restart;
	} in_t;

	typedef struct packed {
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
		logic [LEVEL_BITS-1:0] level;
	} out_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] timer;
		logic                 ended;
	} phase_t;

	function automatic logic [HOLD_BITS-1:0] div100(input logic [LEN_BITS-1:0] x);
		logic [LEN_BITS+16:0] p;
		p = {17'd0, x} * {{LEN_BITS{1'b0}}, RECIP_100};
		return p[RECIP_SHIFT +: HOLD_BITS];
	endfunction

	// Advance the timer one ms; the phase ends once timer+1 reaches len.
	function automatic phase_t phase_step(input logic [TIME_BITS-1:0] t,
			input logic [LEN_BITS-1:0] len);
		logic [TIME_BITS-1:0] nx;
		phase_t r;
		nx = (t == TIMER_MAX) ? t : t + 1'b1;
		if (CMP_BITS'(nx) >= CMP_BITS'(len)) begin
			r.timer = '0;
			r.ended = 1'b1;
		end else begin
			r.timer = nx;
			r.ended = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [7:0] scale_chan(input logic [7:0] c,
			input logic [LEVEL_BITS-1:0] lvl);
		logic [15:0] p;
		p = {8'd0, c} * {8'd0, {1'b0, lvl} + 8'd1};
		return p[15:8];
	endfunction

endpackage

// ----- sv/led_effect_sequencer_top.sv -----
// LED effect sequencer: one colour result per request, state advanced on ms ticks.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_ready  | in_data  (tick, restart)
//  out     | out_valid / out_ready| out_data (red, green, blue, level)
//  cfg     | cfg_we               | cfg_index, cfg_wdata
//
// An accepted request's result is written to the output register in the next cycle;
// one request is taken every clock while the output drains.
// The state update and the fade scaling multipliers sit between the state
// registers and the output register. Fade hold times (time/100) are computed by a
// reciprocal multiply on the configuration write. Reset clears all but out_data_q.
// A stalled output holds its result and blocks new requests only while full.
module led_effect_sequencer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  les_pkg::in_t        in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output les_pkg::out_t       out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [les_pkg::COLOR_BITS-1:0] cfg_wdata
);

	logic [2:0]                         mode_q;
	logic [les_pkg::COLOR_BITS-1:0]     color_q;
	logic [les_pkg::LEN_BITS-1:0]       on_time_q;
	logic [les_pkg::LEN_BITS-1:0]       off_time_q;
	logic [les_pkg::HOLD_BITS-1:0]      on_hold_q;
	logic [les_pkg::HOLD_BITS-1:0]      off_hold_q;

	logic [les_pkg::TIME_BITS-1:0]      timer_q, timer_d;
	logic [les_pkg::LEVEL_BITS-1:0]     level_q, level_d;
	logic falling_q, falling_d;
	logic dark_q, dark_d;
	logic done_q, done_d;
	logic started_q, started_d;

	logic          out_valid_q;
	les_pkg::out_t out_data_q, result;
	les_pkg::phase_t ph;
	logic [les_pkg::HOLD_BITS-1:0] hold;
	logic [les_pkg::COLOR_BITS-1:0] color;
	logic accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration registers; hold times are precomputed here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= les_pkg::MODE_OFF;
			color_q    <= '0;
			on_time_q  <= '0;
			off_time_q <= '0;
			on_hold_q  <= '0;
			off_hold_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				les_pkg::REG_MODE: begin
					mode_q <= cfg_wdata[2:0];
				end
				les_pkg::REG_COLOR: begin
					color_q <= cfg_wdata;
				end
				les_pkg::REG_ON_TIME: begin
					on_time_q <= cfg_wdata[les_pkg::LEN_BITS-1:0];
					on_hold_q <= les_pkg::div100(cfg_wdata[les_pkg::LEN_BITS-1:0]);
				end
				les_pkg::REG_OFF_TIME: begin
					off_time_q <= cfg_wdata[les_pkg::LEN_BITS-1:0];
					off_hold_q <= les_pkg::div100(cfg_wdata[les_pkg::LEN_BITS-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Next state for one request.
	always_comb begin
		timer_d   = timer_q;
		level_d   = level_q;
		falling_d = falling_q;
		dark_d    = dark_q;
		done_d    = done_q;
		started_d = started_q;
		hold      = falling_q ? off_hold_q : on_hold_q;
		ph        = '0;

		if (in_data.restart) begin
			timer_d   = '0;
			dark_d    = 1'b0;
			done_d    = 1'b0;
			started_d = 1'b0;
		end
		if (mode_q != les_pkg::MODE_FADE)
			started_d = 1'b0;

		if (in_data.tick) begin
			case (mode_q)
				les_pkg::MODE_FLICKER: begin
					ph = les_pkg::phase_step(timer_d, dark_d ? off_time_q : on_time_q);
					timer_d = ph.timer;
					if (ph.ended)
						dark_d = !dark_d;
				end
				les_pkg::MODE_FADE: begin
					if (!started_d) begin
						started_d = 1'b1;
						timer_d   = '0;
					end
					ph = les_pkg::phase_step(timer_d, les_pkg::LEN_BITS'(hold));
					timer_d = ph.timer;
					if (ph.ended) begin
						if (!falling_q) begin
							if (level_q + 1'b1 >= les_pkg::FADE_TOP) begin
								level_d   = les_pkg::FADE_TOP;
								falling_d = 1'b1;
							end else begin
								level_d = level_q + 1'b1;
							end
						end else begin
							level_d = (level_q != '0) ? level_q - 1'b1 : level_q;
							if (level_d == '0)
								falling_d = 1'b0;
						end
					end
				end
				les_pkg::MODE_ONESHOT: begin
					if (!done_d) begin
						ph = les_pkg::phase_step(timer_d, on_time_q);
						timer_d = ph.timer;
						if (ph.ended)
							done_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result from the updated state.
	always_comb begin
		case (mode_q)
			les_pkg::MODE_ON:      color = color_q;
			les_pkg::MODE_FLICKER: color = dark_d ? '0 : color_q;
			les_pkg::MODE_FADE:    color = {les_pkg::scale_chan(color_q[23:16], level_d),
					les_pkg::scale_chan(color_q[15:8], level_d),
					les_pkg::scale_chan(color_q[7:0], level_d)};
			les_pkg::MODE_ONESHOT: color = done_d ? '0 : color_q;
			default:               color = '0;
		endcase
		result.red   = color[23:16];
		result.green = color[15:8];
		result.blue  = color[7:0];
		result.level = level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q     <= '0;
			level_q     <= '0;
			falling_q   <= 1'b0;
			dark_q      <= 1'b0;
			done_q      <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				timer_q   <= timer_d;
				level_q   <= level_d;
				falling_q <= falling_d;
				dark_q    <= dark_d;
				done_q    <= done_d;
				started_q <= started_d;
			end
			if (in_ready)
				out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_data_q <= result;
	end

endmodule

// ----- sv/les_checker.sv -----
// Port checker for the LED effect sequencer, bound to the top level.
module les_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input les_pkg::out_t out_data
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Every accepted request yields a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request produced no result");

	// Drop ready only while a result waits on a stalled output.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output state");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.level <= les_pkg::FADE_TOP)
		else $error("fade level above top");

endmodule

bind led_effect_sequencer_top les_checker u_les_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- dv/led_effect_sequencer_top_tb.sv -----
// Testbench for the LED effect sequencer: predicts every color result and checks it in order.

class led_color_checker;
	logic [2:0]          mode;
	logic [23:0]         color;
	logic [15:0]         lit_ms;
	logic [15:0]         dark_ms;
	logic [15:0]         phase_ms;
	int unsigned         level;
	bit                  falling;
	bit                  dark;
	bit                  spent;
	bit                  ramp_loaded;
	les_pkg::out_t       colors_due[$];
	int                  mismatches;

	function new();
		mode = les_pkg::MODE_OFF;
		color = '0;
		lit_ms = '0;
		dark_ms = '0;
		phase_ms = '0;
		level = 0;
		falling = 1'b0;
		dark = 1'b0;
		spent = 1'b0;
		ramp_loaded = 1'b0;
		mismatches = 0;
	endfunction

	function void write_reg(input logic [1:0] idx, input logic [23:0] wdata);
		case (idx)
		les_pkg::REG_MODE: mode = wdata[2:0];
		les_pkg::REG_COLOR: color = wdata;
		les_pkg::REG_ON_TIME: lit_ms = wdata[15:0];
		les_pkg::REG_OFF_TIME: dark_ms = wdata[15:0];
		default: ;
		endcase
	endfunction

	// Count one ms; return 1 and clear the count when a phase of len ms is over.
	function bit count_ms(input logic [15:0] len);
		logic [15:0] nxt;
		nxt = (phase_ms == les_pkg::TIMER_MAX) ? phase_ms : phase_ms + 16'd1;
		if (nxt >= len) begin
			phase_ms = '0;
			return 1'b1;
		end
		phase_ms = nxt;
		return 1'b0;
	endfunction

	function logic [7:0] dim(input logic [7:0] c);
		int unsigned p;
		p = c * (level + 1);
		return 8'(p >> 8);
	endfunction

	function void take_request(input les_pkg::in_t req);
		les_pkg::out_t want;
		logic [23:0]   shown;
		int unsigned   hold;
		if (req.restart) begin
			phase_ms = '0;
			dark = 1'b0;
			spent = 1'b0;
			ramp_loaded = 1'b0;
		end
		if (mode != les_pkg::MODE_FADE)
			ramp_loaded = 1'b0;
		if (req.tick) begin
			case (mode)
			les_pkg::MODE_FLICKER: begin
				if (count_ms(dark ? dark_ms : lit_ms))
					dark = !dark;
			end
			les_pkg::MODE_FADE: begin
				hold = (falling ? dark_ms : lit_ms) / les_pkg::FADE_TOP;
				// first fade tick starts the step timer from zero
				if (!ramp_loaded) begin
					ramp_loaded = 1'b1;
					phase_ms = '0;
				end
				if (count_ms(16'(hold))) begin
					if (!falling) begin
						level++;
						if (level >= les_pkg::FADE_TOP) begin
							level = les_pkg::FADE_TOP;
							falling = 1'b1;
						end
					end else begin
						if (level > 0)
							level--;
						if (level == 0)
							falling = 1'b0;
					end
				end
			end
			les_pkg::MODE_ONESHOT: begin
				if (!spent) begin
					if (count_ms(lit_ms))
						spent = 1'b1;
				end
			end
			default: ;
			endcase
		end
		case (mode)
		les_pkg::MODE_ON: shown = color;
		les_pkg::MODE_FLICKER: shown = dark ? 24'd0 : color;
		les_pkg::MODE_FADE:
			shown = {dim(color[23:16]), dim(color[15:8]), dim(color[7:0])};
		les_pkg::MODE_ONESHOT: shown = spent ? 24'd0 : color;
		default: shown = 24'd0;
		endcase
		want.red = shown[23:16];
		want.green = shown[15:8];
		want.blue = shown[7:0];
		want.level = 7'(level);
		colors_due.push_back(want);
	endfunction

	function void check_color(input les_pkg::out_t got);
		les_pkg::out_t want;
		if (colors_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with no request pending: r=%h g=%h b=%h level=%0d",
					got.red, got.green, got.blue, got.level);
			return;
		end
		want = colors_due.pop_front();
		if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
				got.level !== want.level) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"color mismatch: expected r=%h g=%h b=%h level=%0d,",
					" got r=%h g=%h b=%h level=%0d"},
					want.red, want.green, want.blue, want.level,
					got.red, got.green, got.blue, got.level);
		end
	endfunction
endclass

module led_effect_sequencer_top_tb;

	localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	les_pkg::in_t                   in_data;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	les_pkg::out_t                  out_data;
	logic                           cfg_we;
	logic [1:0]                     cfg_index;
	logic [les_pkg::COLOR_BITS-1:0] cfg_wdata;

	int                    send_idle_pct;
	int                    recv_stall_pct;
	int                    steps_sent;
	led_color_checker      colors;

	led_effect_sequencer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				colors.take_request(in_data);
			if (out_valid && out_ready)
				colors.check_color(out_data);
		end
	end

	// Called at a falling edge; returns at a falling edge with valid dropped.
	task automatic send_step(input bit tick, input bit restart);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_valid = 1'b1;
		in_data.tick = tick;
		in_data.restart = restart;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
		steps_sent++;
	endtask

	task automatic write_reg_port(input logic [1:0] idx, input logic [23:0] wdata);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = wdata;
		colors.write_reg(idx, wdata);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		while (colors.colors_due.size() != 0 && waited < 4000) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
	endtask

	// Write all four registers once the block is idle; junk goes in the unused high bits.
	task automatic apply_setting(input logic [2:0] mode, input logic [23:0] color,
			input logic [15:0] lit, input logic [15:0] dark);
		logic [23:0] noise;
		drain();
		noise = 24'($urandom);
		write_reg_port(les_pkg::REG_MODE, {noise[23:3], mode});
		write_reg_port(les_pkg::REG_COLOR, color);
		write_reg_port(les_pkg::REG_ON_TIME, {noise[23:16], lit});
		write_reg_port(les_pkg::REG_OFF_TIME, {noise[15:8], dark});
	endtask

	function automatic logic [15:0] pick_ms(input bit ramp);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return 16'd0;
		if (r < 15)
			return 16'hFFFF;
		return ramp ? 16'($urandom_range(300)) : 16'($urandom_range(12));
	endfunction

	initial begin
		logic [2:0]  mode;
		logic [23:0] color;
		int unsigned r;
		int unsigned count;
		int unsigned phase;
		colors = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = les_pkg::REG_MODE;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		steps_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset state: black
		send_step(1'b0, 1'b0);
		send_step(1'b1, 1'b0);
		apply_setting(les_pkg::MODE_ON, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
		send_step(1'b0, 1'b0);
		send_step(1'b1, 1'b1);
		// flicker with a zero-length dark phase, then a restart mid-phase
		apply_setting(les_pkg::MODE_FLICKER, 24'h5AA5C3, 16'd2, 16'd0);
		repeat (4) send_step(1'b1, 1'b0);
		send_step(1'b1, 1'b1);
		// one-shot: spend it, re-arm it, then check it stays spent across a mode change
		apply_setting(les_pkg::MODE_ONESHOT, 24'hA53C96, 16'd1, 16'd0);
		send_step(1'b1, 1'b0);
		send_step(1'b0, 1'b0);
		send_step(1'b0, 1'b1);
		send_step(1'b1, 1'b0);
		apply_setting(les_pkg::MODE_ON, 24'h000000, 16'd1, 16'd0);
		send_step(1'b1, 1'b0);
		apply_setting(les_pkg::MODE_ONESHOT, 24'hA53C96, 16'd1, 16'd0);
		send_step(1'b0, 1'b0);
		// fade entered with a leftover timer, unused codes, then fade again
		apply_setting(les_pkg::MODE_FADE, 24'hFFFFFF, 16'd0, 16'hFFFF);
		repeat (3) send_step(1'b1, 1'b0);
		apply_setting(MODE_UNUSED_FIRST, 24'hFFFFFF, 16'd0, 16'hFFFF);
		send_step(1'b1, 1'b0);
		apply_setting(MODE_UNUSED_LAST, 24'hFFFFFF, 16'd0, 16'hFFFF);
		send_step(1'b1, 1'b0);
		apply_setting(les_pkg::MODE_FADE, 24'h8040FF, 16'd150, 16'd99);
		send_step(1'b1, 1'b0);

		phase = 0;
		while (steps_sent < 700) begin
			r = $urandom_range(99);
			if (r < 25)
				mode = les_pkg::MODE_FLICKER;
			else if (r < 50)
				mode = les_pkg::MODE_FADE;
			else if (r < 70)
				mode = les_pkg::MODE_ONESHOT;
			else if (r < 80)
				mode = les_pkg::MODE_ON;
			else if (r < 88)
				mode = les_pkg::MODE_OFF;
			else
				mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
			if ($urandom_range(7) == 0)
				color = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
			else
				color = 24'($urandom);
			apply_setting(mode, color, pick_ms(mode == les_pkg::MODE_FADE),
				pick_ms(mode == les_pkg::MODE_FADE));
			case (phase % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 60;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 60;
			end
			default: begin
				send_idle_pct = 23;
				recv_stall_pct = 23;
			end
			endcase
			// fade needs long runs to climb and fall; level carries over between phases
			count = (mode == les_pkg::MODE_FADE) ? $urandom_range(60, 240) :
				$urandom_range(15, 45);
			if ($urandom_range(1))
				send_step(1'b1, 1'b1);
			repeat (count)
				send_step($urandom_range(99) < 85, $urandom_range(99) < 6);
			phase++;
		end

		drain();
		if (colors.mismatches == 0 && colors.colors_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/les_pkg.sv
sv/led_effect_sequencer_top.sv
sv/les_checker.sv
dv/led_effect_sequencer_top_tb.sv
